// ----- design/male_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the assembly line encoder.
// No dependencies.
package male_pkg;

	localparam int MAX_LINE_CHARS_DEF = 128;
	localparam int MAX_MNEMONIC_CHARS_DEF = 7;

	localparam logic [1:0] K_REG = 2'd1;
	localparam logic [1:0] K_NUM = 2'd2;
	localparam logic [1:0] K_MEM = 2'd3;

	localparam logic [2:0] M_EMPTY  = 3'd0;
	localparam logic [2:0] M_REG    = 3'd1;
	localparam logic [2:0] M_NUM    = 3'd2;
	localparam logic [2:0] M_OPEN   = 3'd3;
	localparam logic [2:0] M_CLOSED = 3'd4;
	localparam logic [2:0] M_BAD    = 3'd5;

	localparam logic [3:0] F_R3   = 4'd0;
	localparam logic [3:0] F_SH   = 4'd1;
	localparam logic [3:0] F_SV   = 4'd2;
	localparam logic [3:0] F_JR   = 4'd3;
	localparam logic [3:0] F_JALR = 4'd4;
	localparam logic [3:0] F_SYS  = 4'd5;
	localparam logic [3:0] F_I    = 4'd6;
	localparam logic [3:0] F_LUI  = 4'd7;
	localparam logic [3:0] F_BR   = 4'd8;
	localparam logic [3:0] F_BGZ  = 4'd9;
	localparam logic [3:0] F_J    = 4'd10;
	localparam logic [3:0] F_ERET = 4'd11;
	localparam logic [3:0] F_NONE = 4'd15;

	localparam logic [31:0] ERET_WORD = 32'h42000018;
	localparam logic [4:0]  BGZ_RT    = 5'd17;

	typedef struct packed {
		logic [3:0] form;
		logic [5:0] code;
	} mn_info_t;

	// register name (packed, right aligned) to number; valid flag in bit 5
	function automatic logic [5:0] reg_lookup(input logic [31:0] nm, input logic [2:0] len);
		logic [5:0] r;
		r = 6'd0;
		case (len)
			3'd2: case (nm[15:0])
				"at": r = {1'b1, 5'd1};
				"v0": r = {1'b1, 5'd2};   "v1": r = {1'b1, 5'd3};
				"a0": r = {1'b1, 5'd4};   "a1": r = {1'b1, 5'd5};
				"a2": r = {1'b1, 5'd6};   "a3": r = {1'b1, 5'd7};
				"t0": r = {1'b1, 5'd8};   "t1": r = {1'b1, 5'd9};
				"t2": r = {1'b1, 5'd10};  "t3": r = {1'b1, 5'd11};
				"t4": r = {1'b1, 5'd12};  "t5": r = {1'b1, 5'd13};
				"t6": r = {1'b1, 5'd14};  "t7": r = {1'b1, 5'd15};
				"s0": r = {1'b1, 5'd16};  "s1": r = {1'b1, 5'd17};
				"s2": r = {1'b1, 5'd18};  "s3": r = {1'b1, 5'd19};
				"s4": r = {1'b1, 5'd20};  "s5": r = {1'b1, 5'd21};
				"s6": r = {1'b1, 5'd22};  "s7": r = {1'b1, 5'd23};
				"t8": r = {1'b1, 5'd24};  "t9": r = {1'b1, 5'd25};
				"k0": r = {1'b1, 5'd26};  "k1": r = {1'b1, 5'd27};
				"gp": r = {1'b1, 5'd28};  "sp": r = {1'b1, 5'd29};
				"fp": r = {1'b1, 5'd30};  "ra": r = {1'b1, 5'd31};
				default: r = 6'd0;
			endcase
			3'd4: r = (nm == "zero") ? {1'b1, 5'd0} : 6'd0;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	function automatic mn_info_t mn_lookup(input logic [63:0] m, input logic [3:0] len);
		mn_info_t e;
		e = '{form: F_NONE, code: 6'd0};
		case (len)
			4'd1: if (m[7:0] == "j") e = '{F_J, 6'd2};
			4'd2: case (m[15:0])
				"or": e = '{F_R3, 6'd37};
				"jr": e = '{F_JR, 6'd8};
				"lw": e = '{F_I, 6'd35};
				"lh": e = '{F_I, 6'd33};
				"sw": e = '{F_I, 6'd43};
				"sh": e = '{F_I, 6'd41};
				default: ;
			endcase
			4'd3: case (m[23:0])
				"add": e = '{F_R3, 6'd32};  "sub": e = '{F_R3, 6'd34};
				"and": e = '{F_R3, 6'd36};  "xor": e = '{F_R3, 6'd38};
				"nor": e = '{F_R3, 6'd39};  "slt": e = '{F_R3, 6'd42};
				"sll": e = '{F_SH, 6'd0};   "srl": e = '{F_SH, 6'd2};
				"sra": e = '{F_SH, 6'd3};   "ori": e = '{F_I, 6'd13};
				"lwx": e = '{F_I, 6'd34};   "lhx": e = '{F_I, 6'd32};
				"lhu": e = '{F_I, 6'd37};   "swx": e = '{F_I, 6'd42};
				"shx": e = '{F_I, 6'd40};   "lui": e = '{F_LUI, 6'd15};
				"beq": e = '{F_BR, 6'd4};   "bne": e = '{F_BR, 6'd5};
				"jal": e = '{F_J, 6'd3};
				default: ;
			endcase
			4'd4: case (m[31:0])
				"addu": e = '{F_R3, 6'd33};  "subu": e = '{F_R3, 6'd35};
				"sltu": e = '{F_R3, 6'd43};  "sllv": e = '{F_SV, 6'd4};
				"srlv": e = '{F_SV, 6'd6};   "srav": e = '{F_SV, 6'd7};
				"jalr": e = '{F_JALR, 6'd9}; "addi": e = '{F_I, 6'd8};
				"andi": e = '{F_I, 6'd12};   "xori": e = '{F_I, 6'd14};
				"slti": e = '{F_I, 6'd10};   "lhux": e = '{F_I, 6'd36};
				"eret": e = '{F_ERET, 6'd16};
				default: ;
			endcase
			4'd5: case (m[39:0])
				"addiu": e = '{F_I, 6'd9};
				"sltiu": e = '{F_I, 6'd11};
				default: ;
			endcase
			4'd6: if (m[47:0] == "bgezal") e = '{F_BGZ, 6'd1};
			4'd7: if (m[55:0] == "syscall") e = '{F_SYS, 6'd12};
			default: ;
		endcase
		return e;
	endfunction

endpackage

// ----- design/male_encode.sv -----
`timescale 1ns / 1ps
// Final word encoder: mnemonic, operand count and operand store to one word.
// Depends on male_pkg.
module male_encode import male_pkg::*; (
	input  logic [63:0] mnem,
	input  logic [3:0]  mnem_len,
	input  logic [2:0]  tok_idx,
	input  logic [31:0] o1,
	input  logic [31:0] o2,
	input  logic [31:0] o3,
	output logic        ok,
	output logic [31:0] word
);
	mn_info_t e;
	logic [1:0] k1, k2, k3;
	logic [4:0] r1, r2, r3;
	logic [31:0] f;
	logic [2:0] n;

	always_comb begin
		e = mn_lookup(mnem, mnem_len);
		k1 = o1[31:30];
		k2 = o2[31:30];
		k3 = o3[31:30];
		r1 = o1[4:0];
		r2 = o2[4:0];
		r3 = o3[4:0];
		f = {26'd0, e.code};
		n = tok_idx + 3'd1;
		ok = 1'b0;
		word = '0;
		unique case (e.form)
			F_R3: begin
				ok = n == 3'd4 && k1 == K_REG && k2 == K_REG && k3 == K_REG;
				word = {6'd0, r2, r3, r1, 5'd0, e.code};
			end
			F_SH: begin
				ok = n == 3'd4 && k1 == K_REG && k2 == K_REG && k3 == K_NUM;
				word = {11'd0, r2, r1, o3[4:0], e.code};
			end
			F_SV: begin
				ok = n == 3'd4 && k1 == K_REG && k2 == K_REG && k3 == K_REG;
				word = {6'd0, r3, r2, r1, 5'd0, e.code};
			end
			F_JR: begin
				ok = n == 3'd2 && k1 == K_REG;
				word = {6'd0, r1, 15'd0, e.code};
			end
			F_JALR: begin
				ok = n == 3'd3 && k1 == K_REG && k2 == K_REG;
				word = {6'd0, r1, 5'd0, r2, 5'd0, e.code};
			end
			F_SYS: begin
				ok = n == 3'd1;
				word = f;
			end
			F_ERET: begin
				ok = n == 3'd1;
				word = ERET_WORD;
			end
			F_I: begin
				if (n == 3'd4 && k1 == K_REG && k2 == K_REG && k3 == K_NUM) begin
					ok = 1'b1;
					word = {e.code, r2, r1, o3[15:0]};
				end else if (n == 3'd3 && k1 == K_REG && k2 == K_MEM) begin
					ok = 1'b1;
					word = {e.code, o2[20:16], r1, o2[15:0]};
				end
			end
			F_LUI: begin
				ok = n == 3'd3 && k1 == K_REG && k2 == K_NUM;
				word = {e.code, 5'd0, r1, o2[15:0]};
			end
			F_BR: begin
				ok = n == 3'd4 && k1 == K_REG && k2 == K_REG && k3 == K_NUM;
				word = {e.code, r1, r2, o3[15:0]};
			end
			F_BGZ: begin
				ok = n == 3'd3 && k1 == K_REG && k2 == K_NUM;
				word = {e.code, r1, BGZ_RT, o2[15:0]};
			end
			F_J: begin
				ok = n == 3'd2 && k1 == K_NUM;
				word = {e.code, o1[25:0]};
			end
			default: ok = 1'b0;
		endcase
	end
endmodule

// ----- design/mips_assembly_line_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the assembly line encoder: character tokenizer and output stage.
// Depends on male_pkg and male_encode.
//
// Feed one ASCII character per transfer on s_axis (tdata = ch, tlast = line
// end). One character is taken every cycle while s_axis is not stalled; the
// tokenizer state is updated by one shallow step per character. On the
// transfer with tlast set, the line is closed, encoded and registered, and
// a word appears on m_axis in the following cycle (tdata = code_word,
// tuser = error). The result register holds while m_axis is stalled;
// s_axis keeps accepting characters then and only stalls when a further
// line end would overwrite an untaken result. A bad line gives all ones
// with error set.
module mips_assembly_line_encoder import male_pkg::*; #(
	parameter int MAX_LINE_CHARS = MAX_LINE_CHARS_DEF,
	parameter int MAX_MNEMONIC_CHARS = MAX_MNEMONIC_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tlast,   // line_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] code_word
	output logic        m_axis_tuser    // [0] error
);
	localparam int CW = $clog2(MAX_LINE_CHARS + 2);

	logic [2:0]  tok_q;
	logic [63:0] mnem_q;
	logic [3:0]  mlen_q;
	logic [31:0] rname_q;
	logic [2:0]  rlen_q;
	logic [31:0] acc_q;
	logic        neg_q, brk_q, fsp_q, err_q, dig_q, spp_q;
	logic [2:0]  mode_q;
	logic [31:0] ops_q [3];
	logic [CW-1:0] cnt_q;

	// next-state copies
	logic [2:0]  tok_n;
	logic [63:0] mnem_n;
	logic [3:0]  mlen_n;
	logic [31:0] rname_n;
	logic [2:0]  rlen_n;
	logic [31:0] acc_n;
	logic        neg_n, brk_n, fsp_n, err_n, dig_n, spp_n;
	logic [2:0]  mode_n;
	logic [31:0] ops_n [3];
	logic [CW-1:0] cnt_n;

	logic [7:0]  c;
	logic        dig, acc_fire, end_fire;
	logic        enc_ok;
	logic [31:0] enc_word;
	logic [5:0]  rl;
	logic [31:0] val, st;

	assign c = s_axis_tdata;
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready || !s_axis_tlast;
	assign acc_fire = s_axis_tvalid && s_axis_tready;
	assign end_fire = acc_fire && s_axis_tlast;
	assign dig = c >= "0" && c <= "9";

	// operand close value from current token state (used only when closing)
	always_comb begin
		rl = reg_lookup(rname_n, rlen_n);
		val = neg_n ? 32'd0 - acc_n : acc_n;
		st = '0;
		if (mode_n == M_REG && !brk_n) begin
			if (rl[5]) st = {K_REG, 25'd0, rl[4:0]};
		end else if (mode_n == M_NUM && dig_n) begin
			st = {K_NUM, 4'd0, val[25:0]};
		end else if (mode_n == M_CLOSED) begin
			if (rl[5]) st = {K_MEM, 9'd0, rl[4:0], val[15:0]};
		end
	end

	// Tokenizer step. A pending space and a comma can both separate on one
	// character: the pending space closes the registered token first, so the
	// comma then closes an empty token.
	logic [5:0]  rl0;
	logic [31:0] val0, st0;
	logic        sep1, sep2;

	always_comb begin
		// first separator (pending space) closes with registered token state
		rl0 = reg_lookup(rname_q, rlen_q);
		val0 = neg_q ? 32'd0 - acc_q : acc_q;
		st0 = '0;
		if (mode_q == M_REG && !brk_q) begin
			if (rl0[5]) st0 = {K_REG, 25'd0, rl0[4:0]};
		end else if (mode_q == M_NUM && dig_q) begin
			st0 = {K_NUM, 4'd0, val0[25:0]};
		end else if (mode_q == M_CLOSED) begin
			if (rl0[5]) st0 = {K_MEM, 9'd0, rl0[4:0], val0[15:0]};
		end
	end

	always_comb begin
		tok_n = tok_q; mnem_n = mnem_q; mlen_n = mlen_q; rname_n = rname_q;
		rlen_n = rlen_q; acc_n = acc_q; neg_n = neg_q; brk_n = brk_q;
		fsp_n = fsp_q; err_n = err_q; dig_n = dig_q; spp_n = spp_q;
		mode_n = mode_q; ops_n = ops_q; cnt_n = cnt_q;
		sep1 = 1'b0; sep2 = 1'b0;

		if (cnt_q <= CW'(MAX_LINE_CHARS)) cnt_n = cnt_q + CW'(1);
		if (cnt_n > CW'(MAX_LINE_CHARS)) err_n = 1'b1;

		if (c == " ") begin
			if ((tok_q != 3'd0 || mlen_q != 4'd0) && !fsp_q) begin
				fsp_n = 1'b1;
				spp_n = 1'b1;
			end
		end else begin
			sep1 = spp_q;
			sep2 = c == ",";
			spp_n = 1'b0;
			if (sep1) begin
				// pending space: close current token with the registered state
				if (tok_q >= 3'd1 && tok_q <= 3'd3) begin
					ops_n[tok_q[1:0] - 2'd1] = st0;
					if (st0 == '0) err_n = 1'b1;
				end
				if (tok_q < 3'd4) tok_n = tok_q + 3'd1;
				if (tok_n == 3'd4) err_n = 1'b1;
				rname_n = '0; acc_n = '0; neg_n = 1'b0; brk_n = 1'b0;
				mode_n = M_EMPTY; rlen_n = '0; dig_n = 1'b0;
			end
			if (sep2) begin
				// token just cleared by a pending space is empty and closes as 0
				if (sep1) begin
					if (tok_n >= 3'd1 && tok_n <= 3'd3) begin
						ops_n[tok_n[1:0] - 2'd1] = '0;
						err_n = 1'b1;
					end
				end else if (tok_n >= 3'd1 && tok_n <= 3'd3) begin
					ops_n[tok_n[1:0] - 2'd1] = st0;
					if (st0 == '0) err_n = 1'b1;
				end
				if (tok_n < 3'd4) tok_n = tok_n + 3'd1;
				if (tok_n == 3'd4) err_n = 1'b1;
				rname_n = '0; acc_n = '0; neg_n = 1'b0; brk_n = 1'b0;
				mode_n = M_EMPTY; rlen_n = '0; dig_n = 1'b0;
			end else if (tok_n == 3'd0) begin
				if (mlen_q < 4'(MAX_MNEMONIC_CHARS)) begin
					mnem_n = {mnem_q[55:0], c};
					mlen_n = mlen_q + 4'd1;
				end else begin
					err_n = 1'b1;
				end
			end else if (tok_n <= 3'd3) begin
				case (mode_n)
					M_EMPTY: begin
						if (c == "$") mode_n = M_REG;
						else if (c == "-") begin mode_n = M_NUM; neg_n = 1'b1; end
						else if (c == "+") mode_n = M_NUM;
						else if (dig) begin
							mode_n = M_NUM; acc_n = {28'd0, c[3:0]}; dig_n = 1'b1;
						end
						else if (c == "(") begin mode_n = M_OPEN; brk_n = 1'b1; end
						else mode_n = M_BAD;
					end
					M_NUM: begin
						if (dig) begin
							acc_n = {acc_n[28:0], 3'd0} + {acc_n[30:0], 1'b0}
								+ {28'd0, c[3:0]};
							dig_n = 1'b1;
						end else if (c == "(") begin
							mode_n = M_OPEN; brk_n = 1'b1;
						end else mode_n = M_BAD;
					end
					M_OPEN: mode_n = (c == "$") ? M_REG : M_BAD;
					M_REG: begin
						if (c == ")" && brk_n) mode_n = M_CLOSED;
						else if (rlen_n < 3'd4) begin
							rname_n = {rname_n[23:0], c};
							rlen_n = rlen_n + 3'd1;
						end else mode_n = M_BAD;
					end
					default: mode_n = M_BAD;
				endcase
			end
		end
	end

	// line end: close the final operand from the updated state
	logic [31:0] fo [3];
	logic        ferr;
	always_comb begin
		fo = ops_n;
		ferr = err_n;
		if (tok_n >= 3'd1 && tok_n <= 3'd3) begin
			fo[tok_n[1:0] - 2'd1] = st;
			if (st == '0) ferr = 1'b1;
		end
	end

	male_encode u_enc (
		.mnem(mnem_n), .mnem_len(mlen_n), .tok_idx(tok_n),
		.o1(fo[0]), .o2(fo[1]), .o3(fo[2]),
		.ok(enc_ok), .word(enc_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0; mnem_q <= '0; mlen_q <= '0; rname_q <= '0; rlen_q <= '0;
			acc_q <= '0; neg_q <= 1'b0; brk_q <= 1'b0; fsp_q <= 1'b0;
			err_q <= 1'b0; dig_q <= 1'b0; spp_q <= 1'b0; mode_q <= M_EMPTY;
			ops_q <= '{default: '0}; cnt_q <= '0;
		end else if (acc_fire) begin
			if (s_axis_tlast) begin
				tok_q <= '0; mnem_q <= '0; mlen_q <= '0; rname_q <= '0; rlen_q <= '0;
				acc_q <= '0; neg_q <= 1'b0; brk_q <= 1'b0; fsp_q <= 1'b0;
				err_q <= 1'b0; dig_q <= 1'b0; spp_q <= 1'b0; mode_q <= M_EMPTY;
				ops_q <= '{default: '0}; cnt_q <= '0;
			end else begin
				tok_q <= tok_n; mnem_q <= mnem_n; mlen_q <= mlen_n;
				rname_q <= rname_n; rlen_q <= rlen_n; acc_q <= acc_n;
				neg_q <= neg_n; brk_q <= brk_n; fsp_q <= fsp_n; err_q <= err_n;
				dig_q <= dig_n; spp_q <= spp_n; mode_q <= mode_n;
				ops_q <= ops_n; cnt_q <= cnt_n;
			end
		end
	end

	// result register
	logic good;
	assign good = !ferr && tok_n <= 3'd3 && enc_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (end_fire) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_fire) begin
			m_axis_tdata <= good ? enc_word : '1;
			m_axis_tuser <= !good;
		end
	end
endmodule

// ----- test/tb_mips_assembly_line_encoder.sv -----
`timescale 1ns / 1ps
// Testbench for mips_assembly_line_encoder: streams assembly lines one character
// per transfer and checks each encoded word against an in-bench line encoder.
// Depends on male_pkg and the encoder RTL.
module tb_mips_assembly_line_encoder;
	import male_pkg::*;

	localparam int LINE_LIMIT = MAX_LINE_CHARS_DEF;
	localparam int MNEM_LIMIT = MAX_MNEMONIC_CHARS_DEF;
	localparam int N_MNEM = 43;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_t;

	typedef struct packed {
		logic [31:0] word;
		logic        err;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tuser;

	mips_assembly_line_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	// mnemonic and register spelling tables
	string mn_txt[N_MNEM] = '{"add", "addu", "sub", "subu", "and", "or", "xor", "nor",
		"slt", "sltu", "sll", "srl", "sra", "sllv", "srlv", "srav", "jr", "jalr",
		"syscall", "addi", "addiu", "andi", "ori", "xori", "slti", "sltiu", "lw",
		"lwx", "lh", "lhx", "lhu", "lhux", "sw", "swx", "sh", "shx", "lui", "beq",
		"bne", "bgezal", "j", "jal", "eret"};
	logic [3:0] mn_form[N_MNEM] = '{F_R3, F_R3, F_R3, F_R3, F_R3, F_R3, F_R3, F_R3,
		F_R3, F_R3, F_SH, F_SH, F_SH, F_SV, F_SV, F_SV, F_JR, F_JALR, F_SYS,
		F_I, F_I, F_I, F_I, F_I, F_I, F_I, F_I, F_I, F_I, F_I, F_I, F_I, F_I,
		F_I, F_I, F_I, F_LUI, F_BR, F_BR, F_BGZ, F_J, F_J, F_ERET};
	logic [5:0] mn_code[N_MNEM] = '{32, 33, 34, 35, 36, 37, 38, 39, 42, 43, 0, 2, 3,
		4, 6, 7, 8, 9, 12, 8, 9, 12, 13, 14, 10, 11, 35, 34, 33, 32, 37, 36, 43,
		42, 41, 40, 15, 4, 5, 1, 2, 3, 16};
	string reg_txt[32] = '{"zero", "at", "v0", "v1", "a0", "a1", "a2", "a3",
		"t0", "t1", "t2", "t3", "t4", "t5", "t6", "t7", "s0", "s1", "s2", "s3",
		"s4", "s5", "s6", "s7", "t8", "t9", "k0", "k1", "gp", "sp", "fp", "ra"};

	// line parser shadow state
	int          tok_idx, mn_len, rname_len, char_cnt;
	logic [63:0] mn_chars;
	logic [31:0] rname, num_acc;
	logic [31:0] opnd[3];
	logic        num_neg, in_brk, first_sp, line_bad, got_digit, sp_pending;
	logic [2:0]  tok_mode;

	char_t pending_chars[$];
	word_t expected_words[$];
	int    n_sent = 0, n_lines = 0, n_words = 0, n_bad_lines = 0, n_fail = 0;
	int    n_total = 1;

	function automatic logic [63:0] pack_txt(string s);
		logic [63:0] v;
		v = 64'd0;
		for (int i = 0; i < s.len(); i++)
			v = {v[55:0], s[i]};
		return v;
	endfunction

	// register number with a valid flag in bit 5
	function automatic logic [5:0] reg_number();
		for (int i = 0; i < 32; i++)
			if (reg_txt[i].len() == rname_len && pack_txt(reg_txt[i]) == {32'd0, rname})
				return {1'b1, 5'(i)};
		return 6'd0;
	endfunction

	function automatic void clear_token();
		rname = 0; num_acc = 0; num_neg = 0; in_brk = 0;
		tok_mode = M_EMPTY; rname_len = 0; got_digit = 0;
	endfunction

	function automatic void clear_line();
		tok_idx = 0; mn_chars = 0; mn_len = 0; first_sp = 0;
		opnd[0] = 0; opnd[1] = 0; opnd[2] = 0;
		line_bad = 0; char_cnt = 0; sp_pending = 0;
		clear_token();
	endfunction

	function automatic void close_operand();
		logic [31:0] val, st;
		logic [5:0]  r;
		val = num_neg ? -num_acc : num_acc;
		st = 0;
		r = reg_number();
		if (tok_mode == M_REG && !in_brk) begin
			if (r[5]) st = {K_REG, 25'd0, r[4:0]};
		end else if (tok_mode == M_NUM && got_digit) begin
			st = {K_NUM, 4'd0, val[25:0]};
		end else if (tok_mode == M_CLOSED) begin
			if (r[5]) st = {K_MEM, 9'd0, r[4:0], val[15:0]};
		end
		if (st == 0) line_bad = 1;
		opnd[tok_idx - 1] = st;
	endfunction

	function automatic void next_token();
		if (tok_idx >= 1 && tok_idx <= 3) close_operand();
		if (tok_idx < 4) tok_idx++;
		if (tok_idx == 4) line_bad = 1;
		clear_token();
	endfunction

	function automatic void operand_char(logic [7:0] c);
		logic dig;
		dig = (c >= "0" && c <= "9");
		case (tok_mode)
			M_EMPTY: begin
				if (c == "$") tok_mode = M_REG;
				else if (c == "-") begin tok_mode = M_NUM; num_neg = 1; end
				else if (c == "+") tok_mode = M_NUM;
				else if (dig) begin
					tok_mode = M_NUM; num_acc = c - "0"; got_digit = 1;
				end else if (c == "(") begin tok_mode = M_OPEN; in_brk = 1; end
				else tok_mode = M_BAD;
			end
			M_NUM: begin
				if (dig) begin num_acc = num_acc * 10 + (c - "0"); got_digit = 1; end
				else if (c == "(") begin tok_mode = M_OPEN; in_brk = 1; end
				else tok_mode = M_BAD;
			end
			M_OPEN: tok_mode = (c == "$") ? M_REG : M_BAD;
			M_REG: begin
				if (c == ")" && in_brk) tok_mode = M_CLOSED;
				else if (rname_len < 4) begin rname = {rname[23:0], c}; rname_len++; end
				else tok_mode = M_BAD;
			end
			default: tok_mode = M_BAD;
		endcase
	endfunction

	// instruction word from the finished line; returns 0 when it does not encode
	function automatic logic encode_line(output logic [31:0] w);
		int k, n;
		logic [1:0] k1, k2, k3;
		logic [4:0] r1, r2, r3;
		logic [31:0] f;
		k = -1;
		n = tok_idx + 1;
		w = 0;
		for (int i = 0; i < N_MNEM; i++)
			if (k < 0 && mn_txt[i].len() == mn_len && pack_txt(mn_txt[i]) == mn_chars) k = i;
		if (k < 0) return 0;
		k1 = opnd[0][31:30]; k2 = opnd[1][31:30]; k3 = opnd[2][31:30];
		r1 = opnd[0][4:0]; r2 = opnd[1][4:0]; r3 = opnd[2][4:0];
		f = 32'(mn_code[k]);
		case (mn_form[k])
			F_R3: begin
				if (n != 4 || k1 != K_REG || k2 != K_REG || k3 != K_REG) return 0;
				w = (r2 << 21) | (r3 << 16) | (r1 << 11) | f;
			end
			F_SH: begin
				if (n != 4 || k1 != K_REG || k2 != K_REG || k3 != K_NUM) return 0;
				w = (r2 << 16) | (r1 << 11) | (opnd[2][4:0] << 6) | f;
			end
			F_SV: begin
				if (n != 4 || k1 != K_REG || k2 != K_REG || k3 != K_REG) return 0;
				w = (r3 << 21) | (r2 << 16) | (r1 << 11) | f;
			end
			F_JR: begin
				if (n != 2 || k1 != K_REG) return 0;
				w = (r1 << 21) | f;
			end
			F_JALR: begin
				if (n != 3 || k1 != K_REG || k2 != K_REG) return 0;
				w = (r1 << 21) | (r2 << 11) | f;
			end
			F_SYS: begin
				if (n != 1) return 0;
				w = 32'd12;
			end
			F_ERET: begin
				if (n != 1) return 0;
				w = ERET_WORD;
			end
			F_I: begin
				if (n == 4 && k1 == K_REG && k2 == K_REG && k3 == K_NUM)
					w = (f << 26) | (r2 << 21) | (r1 << 16) | opnd[2][15:0];
				else if (n == 3 && k1 == K_REG && k2 == K_MEM)
					w = (f << 26) | (opnd[1][20:16] << 21) | (r1 << 16) | opnd[1][15:0];
				else
					return 0;
			end
			F_LUI: begin
				if (n != 3 || k1 != K_REG || k2 != K_NUM) return 0;
				w = (f << 26) | (r1 << 16) | opnd[1][15:0];
			end
			F_BR: begin
				if (n != 4 || k1 != K_REG || k2 != K_REG || k3 != K_NUM) return 0;
				w = (f << 26) | (r1 << 21) | (r2 << 16) | opnd[2][15:0];
			end
			F_BGZ: begin
				if (n != 3 || k1 != K_REG || k2 != K_NUM) return 0;
				w = (f << 26) | (r1 << 21) | (32'(BGZ_RT) << 16) | opnd[1][15:0];
			end
			F_J: begin
				if (n != 2 || k1 != K_NUM) return 0;
				w = (f << 26) | opnd[0][25:0];
			end
			default: return 0;
		endcase
		return 1;
	endfunction

	// one character in; queues the expected word when the line ends
	function automatic void take_char(logic [7:0] c, logic last);
		logic [31:0] w;
		logic ok;
		if (char_cnt <= LINE_LIMIT) char_cnt++;
		if (char_cnt > LINE_LIMIT) line_bad = 1;
		if (c == " ") begin
			if ((tok_idx != 0 || mn_len != 0) && !first_sp) begin
				first_sp = 1; sp_pending = 1;
			end
		end else begin
			if (sp_pending) begin next_token(); sp_pending = 0; end
			if (c == ",") next_token();
			else if (tok_idx == 0) begin
				if (mn_len < MNEM_LIMIT) begin mn_chars = {mn_chars[55:0], c}; mn_len++; end
				else line_bad = 1;
			end else if (tok_idx <= 3) operand_char(c);
		end
		if (!last) return;
		if (tok_idx >= 1 && tok_idx <= 3) close_operand();
		ok = !line_bad && tok_idx <= 3 && encode_line(w);
		expected_words.insert(expected_words.size(),
			word_t'{ok ? w : 32'hFFFF_FFFF, !ok});
		n_lines++;
		if (!ok) n_bad_lines++;
		clear_line();
	endfunction

	// ---------------- stimulus text ----------------
	function automatic void queue_line(string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.insert(pending_chars.size(), char_t'{s[i], i == s.len() - 1});
	endfunction

	function automatic string any_reg();
		return {"$", reg_txt[$urandom_range(0, 31)]};
	endfunction

	function automatic string any_num();
		string s;
		case ($urandom_range(0, 3))
			0: s = "-";
			1: s = "+";
			default: s = "";
		endcase
		if ($urandom_range(0, 2) == 0) begin
			for (int i = $urandom_range(1, 12); i > 0; i--)
				s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		end else begin
			s = {s, $sformatf("%0d", $urandom_range(0, 70000))};
		end
		return s;
	endfunction

	function automatic string any_mem();
		return {($urandom_range(0, 4) == 0) ? "" : any_num(), "(", any_reg(), ")"};
	endfunction

	function automatic string pad_spaces();
		return ($urandom_range(0, 3) == 0) ? "  " : (($urandom_range(0, 2) == 0) ? " " : "");
	endfunction

	// a well-formed line for a random mnemonic, now and then damaged
	function automatic string build_line();
		int k;
		string s, a, b, c;
		k = $urandom_range(0, N_MNEM - 1);
		a = any_reg(); b = any_reg(); c = any_reg();
		case (mn_form[k])
			F_R3, F_SV: s = {a, ",", b, ",", c};
			F_SH, F_BR: s = {a, ",", b, ",", any_num()};
			F_JR:       s = a;
			F_JALR:     s = {a, ",", b};
			F_I:        s = $urandom_range(0, 1) ? {a, ",", b, ",", any_num()} : {a, ",", any_mem()};
			F_LUI, F_BGZ: s = {a, ",", any_num()};
			F_J:        s = any_num();
			default:    s = "";
		endcase
		s = {pad_spaces(), mn_txt[k], (s == "") ? "" : ($urandom_range(0, 3) == 0 ? "," : " "),
			s, pad_spaces()};
		if ($urandom_range(0, 6) == 0) begin
			k = $urandom_range(0, s.len() - 1);
			s[k] = 8'($urandom_range(1, 255));
		end
		return s;
	endfunction

	// random bytes leaning on the characters that steer the tokenizer
	function automatic string noise_line(int len);
		string s, pool;
		pool = "$(),+- 0123456789atvszero";
		s = "";
		for (int i = 0; i < len; i++)
			s = {s, $urandom_range(0, 1) ? string'(pool[$urandom_range(0, pool.len() - 1)])
				: string'(8'($urandom_range(1, 255)))};
		return s;
	endfunction

	function automatic string long_line(int len);
		string s;
		s = "add $t0,$t1,$t2";
		while (s.len() < len) s = {s, " "};
		return s;
	endfunction

	// ---------------- driver ----------------
	int send_idle_pct, recv_idle_pct;
	always_comb begin
		if (n_sent < n_total / 3) begin
			send_idle_pct = 37; recv_idle_pct = 72;
		end else if (n_sent < 2 * n_total / 3) begin
			send_idle_pct = 72; recv_idle_pct = 37;
		end else begin
			send_idle_pct = 0; recv_idle_pct = 0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		char_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			clear_line();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				take_char(s_axis_tdata, s_axis_tlast);
				n_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_chars.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_chars.pop_front();
					s_axis_tdata <= nxt.ch;
					s_axis_tlast <= nxt.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		word_t exp_w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected transfer: code_word %h error %b", m_axis_tdata,
						m_axis_tuser);
					n_fail++;
				end else begin
					exp_w = expected_words.pop_front();
					n_words++;
					if (m_axis_tdata !== exp_w.word) begin
						$error("code_word: expected %h actual %h", exp_w.word, m_axis_tdata);
						n_fail++;
					end
					if (m_axis_tuser !== exp_w.err) begin
						$error("error: expected %b actual %b", exp_w.err, m_axis_tuser);
						n_fail++;
					end
				end
			end
		end
	end

	// ---------------- test sequence ----------------
	initial begin
		// every form, field extremes and the named invalid cases
		queue_line("add $t0,$s1,$ra");
		queue_line("sll $a0 $zero,31");
		queue_line("sra $a0,$zero,4294967295");
		queue_line("srav $v0,$v1,$k1");
		queue_line("jr $ra");
		queue_line("jalr $t9,$ra");
		queue_line("syscall");
		queue_line("eret");
		queue_line("addi $sp,$sp,-4");
		queue_line("lw $t0,8($sp)");
		queue_line("sw $a0,($gp)");
		queue_line("lh $t1,-32768($fp)");
		queue_line("lui $at,65535");
		queue_line("beq $t0,$t1,-1");
		queue_line("bgezal $s0,+100");
		queue_line("j 67108863");
		queue_line("jal 99999999999");
		queue_line("mfc0 $t0,$12");
		queue_line("  or   $at,$v0,$v1  ");
		queue_line("add $t0,$t1");
		queue_line("add $t0,$t1,$t2,$t3,$t4");
		queue_line("ADD $t0,$t1,$t2");
		queue_line("add $t00,$t1,$t2");
		queue_line("lw $t0,+($sp)");
		queue_line("syscalls");
		queue_line(",");
		queue_line(long_line(129));
		queue_line(long_line(128));
		// random lines: mostly well-formed, some noise and long lines
		while (pending_chars.size() < 1900) begin
			case ($urandom_range(0, 19))
				0, 1: queue_line(noise_line($urandom_range(1, 16)));
				2: if ($urandom_range(0, 9) == 0) queue_line(long_line($urandom_range(127, 140)));
				default: queue_line(build_line());
			endcase
		end
		n_total = pending_chars.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_chars.size() == 0 && !s_axis_tvalid && expected_words.size() == 0);
		repeat (10) @(posedge clk);
		$display("%0d characters in %0d lines, %0d words checked, %0d lines flagged bad",
			n_sent, n_lines, n_words, n_bad_lines);
		if (n_fail == 0 && expected_words.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/male_pkg.sv
design/male_encode.sv
design/mips_assembly_line_encoder.sv
test/tb_mips_assembly_line_encoder.sv
